// ===== sv/iba_pkg.sv =====
// Shared types and constants for the indexed block allocator.
// Holds opcode and status codes and the controller/datapath command and status structs.
// No dependencies.
package iba_pkg;

  localparam int BLOCK_COUNT_DEF = 16;
  localparam int MAX_FILES_DEF   = 8;
  localparam int ID_BITS_DEF     = 16;

  localparam int OP_W   = 3;
  localparam int ID_W   = 16;
  localparam int LEN_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ST_W   = 3;
  localparam int BLK_W  = 6;
  localparam int CNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_DISCARD   = 3'd5,
    ST_BUSY      = 3'd6
  } status_e;

  // source of the fields of an emitted result
  typedef enum logic [1:0] {
    EM_CODE  = 2'd0,
    EM_BEGIN = 2'd1,
    EM_WRITE = 2'd2,
    EM_READ  = 2'd3
  } emit_e;

  typedef struct packed {
    logic    cap;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    srch;
    logic    alloc;
    logic    wr;
    logic    wr_fail;
    logic    bw;
    logic    bm_rd;
    logic    rd_data;
    logic    fr_apply;
    logic    del;
    logic    emit;
    emit_e   kind;
    status_e code;
  } iba_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             write_open;
    logic             hit;
    logic             free_hit;
    logic [CNT_W-1:0] cnt;
    logic             blk_free_now;
    logic [LEN_W-1:0] len_cur;
    logic             slot_full;
    logic             out_free;
  } iba_stat_t;

endpackage

// ===== sv/iba_dp.sv =====
// Datapath of the indexed block allocator: block and entry tables, the index
// list and data memories, the shared step counter and the result register.
// Depends on iba_pkg.
module iba_dp import iba_pkg::*; #(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int MAX_FILES   = MAX_FILES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ID_W-1:0]   file_id_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [CHAR_W-1:0] data_char_i,
  input  iba_cmd_t          cmd_i,
  output iba_stat_t         stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic [BLK_W-1:0]  block_index_o,
  output logic              last_o
);

  localparam int BW  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int EW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int AW  = (MAX_FILES * BLOCK_COUNT > 1) ? $clog2(MAX_FILES * BLOCK_COUNT) : 1;
  localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [AW-1:0]    NB_A  = AW'(BLOCK_COUNT);
  localparam logic [CNT_W-1:0] NB_C  = CNT_W'(BLOCK_COUNT);
  localparam logic [LEN_W-1:0] NB_L  = LEN_W'(BLOCK_COUNT);

  logic [OP_W-1:0]   op_q;
  logic [IDW-1:0]    id_q;
  logic [LEN_W-1:0]  len_q;
  logic [CHAR_W-1:0] ch_q;

  logic [BLOCK_COUNT-1:0] block_free_q;
  logic [MAX_FILES-1:0]   entry_valid_q;
  logic [IDW-1:0]         entry_id_q  [MAX_FILES];
  logic [LEN_W-1:0]       entry_len_q [MAX_FILES];
  logic [LEN_W-1:0]       free_count_q;
  logic                   write_open_q;
  logic [EW-1:0]          write_entry_q;
  logic [LEN_W-1:0]       pending_q;

  logic [CNT_W-1:0] cnt_q;
  logic             hit_q, free_hit_q;
  logic [EW-1:0]    cur_e_q, free_e_q;

  logic [BW-1:0]     bm_mem [MAX_FILES * BLOCK_COUNT];
  logic [CHAR_W-1:0] dm_mem [BLOCK_COUNT];
  logic [BW-1:0]     bm_q;
  logic [CHAR_W-1:0] dm_q;

  logic              out_valid_q;
  logic [ST_W-1:0]   status_q;
  logic [CHAR_W-1:0] out_char_q;
  logic [BLK_W-1:0]  block_q;
  logic              last_q;

  logic [EW-1:0]    e_cnt;
  logic [BW-1:0]    b_cnt;
  logic [LEN_W-1:0] slot;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             out_free;
  status_e          bw_status;
  logic             rd_last;

  assign e_cnt    = cnt_q[EW-1:0];
  assign b_cnt    = cnt_q[BW-1:0];
  assign slot     = entry_len_q[write_entry_q];
  assign wr_addr  = AW'(write_entry_q) * NB_A + AW'(slot);
  assign rd_addr  = AW'(cur_e_q) * NB_A + AW'(cnt_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_last  = (LEN_W'(cnt_q) + LEN_W'(1)) == entry_len_q[cur_e_q];

  always_comb begin
    if (len_q > free_count_q) begin
      bw_status = ST_NO_SPACE;
    end else begin
      bw_status = ST_OK;
    end
  end

  always_comb begin
    stat_o.op           = op_q;
    stat_o.write_open   = write_open_q;
    stat_o.hit          = hit_q;
    stat_o.free_hit     = free_hit_q;
    stat_o.cnt          = cnt_q;
    stat_o.blk_free_now = (cnt_q < NB_C) && block_free_q[b_cnt];
    stat_o.len_cur      = entry_len_q[cur_e_q];
    stat_o.slot_full    = slot >= NB_L;
    stat_o.out_free     = out_free;
  end

  // captured transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q  <= opcode_i;
      id_q  <= file_id_i[IDW-1:0];
      len_q <= length_i;
      ch_q  <= data_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      hit_q      <= 1'b0;
      free_hit_q <= 1'b0;
    end else begin
      if (cmd_i.cap || cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.cap) begin
        hit_q      <= 1'b0;
        free_hit_q <= 1'b0;
      end else if (cmd_i.srch) begin
        if (entry_valid_q[e_cnt] && entry_id_q[e_cnt] == id_q) begin
          hit_q <= 1'b1;
        end
        if (!entry_valid_q[e_cnt] && !free_hit_q) begin
          free_hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch) begin
      if (entry_valid_q[e_cnt] && entry_id_q[e_cnt] == id_q) begin
        cur_e_q <= e_cnt;
      end
      if (!entry_valid_q[e_cnt] && !free_hit_q) begin
        free_e_q <= e_cnt;
      end
    end else if (cmd_i.alloc) begin
      cur_e_q <= free_e_q;
    end
    if (cmd_i.alloc) begin
      entry_id_q[free_e_q] <= id_q;
    end
    if (cmd_i.bw) begin
      entry_len_q[cur_e_q] <= '0;
    end else if (cmd_i.wr) begin
      entry_len_q[write_entry_q] <= slot + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_free_q  <= '1;
      entry_valid_q <= '0;
      free_count_q  <= NB_L;
      write_open_q  <= 1'b0;
      write_entry_q <= '0;
      pending_q     <= '0;
    end else begin
      if (cmd_i.alloc) begin
        entry_valid_q[free_e_q] <= 1'b1;
      end
      if (cmd_i.del) begin
        entry_valid_q[cur_e_q] <= 1'b0;
      end
      if (cmd_i.bw && len_q <= free_count_q && len_q != '0) begin
        free_count_q  <= free_count_q - len_q;
        write_open_q  <= 1'b1;
        write_entry_q <= cur_e_q;
        pending_q     <= len_q;
      end
      if (cmd_i.wr) begin
        block_free_q[b_cnt] <= 1'b0;
        if (pending_q != '0) begin
          pending_q <= pending_q - LEN_W'(1);
        end
        if (pending_q <= LEN_W'(1)) begin
          write_open_q <= 1'b0;
        end
      end
      if (cmd_i.wr_fail) begin
        write_open_q <= 1'b0;
        pending_q    <= '0;
      end
      if (cmd_i.fr_apply && !block_free_q[bm_q]) begin
        block_free_q[bm_q] <= 1'b1;
        free_count_q       <= free_count_q + LEN_W'(1);
      end
    end
  end

  // index list memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      bm_mem[wr_addr] <= b_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bm_rd) begin
      bm_q <= bm_mem[rd_addr];
    end
  end

  // block data memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      dm_mem[b_cnt] <= ch_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_data) begin
      dm_q <= dm_mem[bm_q];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.kind)
        EM_BEGIN: begin
          status_q   <= bw_status;
          out_char_q <= '0;
          block_q    <= '0;
          last_q     <= 1'b1;
        end
        EM_WRITE: begin
          status_q   <= ST_OK;
          out_char_q <= '0;
          block_q    <= BLK_W'(b_cnt);
          last_q     <= 1'b1;
        end
        EM_READ: begin
          status_q   <= ST_OK;
          out_char_q <= dm_q;
          block_q    <= BLK_W'(bm_q);
          last_q     <= rd_last;
        end
        default: begin
          status_q   <= cmd_i.code;
          out_char_q <= '0;
          block_q    <= '0;
          last_q     <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_char_o    = out_char_q;
  assign block_index_o = block_q;
  assign last_o        = last_q;

  a_free_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= NB_L)
    else $error("free count above block count");

  a_open_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_open_q |-> pending_q != '0)
    else $error("write open with nothing pending");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result register overwritten");

  a_wr_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> write_open_q && block_free_q[b_cnt])
    else $error("char stored without open write or into used block");

endmodule

// ===== sv/iba_ctrl.sv =====
// Controller of the indexed block allocator: one-hot state machine that
// sequences searches, scans, reads and frees through datapath commands.
// Depends on iba_pkg.
module iba_ctrl import iba_pkg::*; #(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int MAX_FILES   = MAX_FILES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  iba_stat_t stat_i,
  output iba_cmd_t  cmd_o
);

  localparam logic [CNT_W-1:0] NB_C   = CNT_W'(BLOCK_COUNT);
  localparam logic [CNT_W-1:0] LAST_E = CNT_W'(MAX_FILES - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DISP   = 12'b0000_0000_0010,
    S_SRCH   = 12'b0000_0000_0100,
    S_DECIDE = 12'b0000_0000_1000,
    S_SCAN   = 12'b0000_0001_0000,
    S_BEGIN  = 12'b0000_0010_0000,
    S_RA     = 12'b0000_0100_0000,
    S_RD     = 12'b0000_1000_0000,
    S_RE     = 12'b0001_0000_0000,
    S_FA     = 12'b0010_0000_0000,
    S_FP     = 12'b0100_0000_0000,
    S_DEL    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   rd_last;

  assign rd_last = (LEN_W'(stat_i.cnt) + LEN_W'(1)) == stat_i.len_cur;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.op > OP_DELETE || (stat_i.op == OP_WRITE && !stat_i.write_open)) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = ST_DISCARD;
            state_d    = S_IDLE;
          end
        end else if (stat_i.op == OP_WRITE) begin
          state_d = S_SCAN;
        end else if (stat_i.write_open) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = ST_BUSY;
            state_d    = S_IDLE;
          end
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SCAN: begin
        if (stat_i.slot_full || stat_i.cnt >= NB_C) begin
          if (stat_i.out_free) begin
            cmd_o.wr_fail = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.code    = ST_NO_SPACE;
            state_d       = S_IDLE;
          end
        end else if (stat_i.blk_free_now) begin
          if (stat_i.out_free) begin
            cmd_o.wr   = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.kind = EM_WRITE;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_SRCH: begin
        cmd_o.srch    = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt == LAST_E) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.cnt_clr = 1'b1;
        if (stat_i.op == OP_CREATE) begin
          if (stat_i.hit || !stat_i.free_hit) begin
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.code = stat_i.hit ? ST_DUP : ST_FULL;
              state_d    = S_IDLE;
            end
          end else begin
            cmd_o.alloc = 1'b1;
            state_d     = S_BEGIN;
          end
        end else if (!stat_i.hit) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = ST_NOT_FOUND;
            state_d    = S_IDLE;
          end
        end else if (stat_i.op == OP_READ) begin
          if (stat_i.len_cur == '0) begin
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.code = ST_OK;
              state_d    = S_IDLE;
            end
          end else begin
            state_d = S_RA;
          end
        end else begin
          state_d = S_FA;
        end
      end
      S_BEGIN: begin
        if (stat_i.out_free) begin
          cmd_o.bw   = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_BEGIN;
          state_d    = S_IDLE;
        end
      end
      S_RA: begin
        cmd_o.bm_rd = 1'b1;
        state_d     = S_RD;
      end
      S_RD: begin
        cmd_o.rd_data = 1'b1;
        state_d       = S_RE;
      end
      S_RE: begin
        if (stat_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = EM_READ;
          cmd_o.cnt_inc = 1'b1;
          state_d       = rd_last ? S_IDLE : S_RA;
        end
      end
      S_FA: begin
        if (LEN_W'(stat_i.cnt) >= stat_i.len_cur) begin
          state_d = (stat_i.op == OP_UPDATE) ? S_BEGIN : S_DEL;
        end else begin
          cmd_o.bm_rd = 1'b1;
          state_d     = S_FP;
        end
      end
      S_FP: begin
        cmd_o.fr_apply = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        state_d        = S_FA;
      end
      S_DEL: begin
        if (stat_i.out_free) begin
          cmd_o.del  = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.code = ST_OK;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  a_cap_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |=> state_q == S_DISP)
    else $error("capture did not dispatch");

  a_read_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RA |=> state_q == S_RD ##1 state_q == S_RE)
    else $error("read sequence broken");

endmodule

// ===== sv/indexed_block_allocator_top.sv =====
// Indexed block allocator, one transaction at a time; output stalls hold it up.
// A write char takes the lowest free block, found by a scan; other ops first search
// the whole file table. A read fetches each char's index, then its data, before its
// result; update/delete free the file's blocks one by one.
// A new transaction is taken while the last result waits in the output register.
// Reset (async, active low) frees every block, clears the file table, closes writes.
module indexed_block_allocator_top import iba_pkg::*; #(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int MAX_FILES   = MAX_FILES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ID_W-1:0]   file_id_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [CHAR_W-1:0] data_char_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic [BLK_W-1:0]  block_index_o,
  output logic              last_o
);

  iba_cmd_t  cmd;
  iba_stat_t stat;

  iba_ctrl #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .MAX_FILES  (MAX_FILES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  iba_dp #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .MAX_FILES  (MAX_FILES),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .file_id_i    (file_id_i),
    .length_i     (length_i),
    .data_char_i  (data_char_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_char_o   (out_char_o),
    .block_index_o(block_index_o),
    .last_o       (last_o)
  );

endmodule

// ===== sim/tb.sv =====
// Testbench for indexed_block_allocator_top: directed and random file transactions.
// A local model of the allocator predicts every result; a monitor checks them in order.
// Depends on iba_pkg and the allocator RTL.
module tb;
  import iba_pkg::*;

  localparam int NBLK = BLOCK_COUNT_DEF;
  localparam int NFIL = MAX_FILES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CHAR_W-1:0] ch;
    logic [BLK_W-1:0]  blk;
    logic              last;
  } result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [ID_W-1:0]   file_id_i;
  logic [LEN_W-1:0]  length_i;
  logic [CHAR_W-1:0] data_char_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ST_W-1:0]   status_o;
  logic [CHAR_W-1:0] out_char_o;
  logic [BLK_W-1:0]  block_index_o;
  logic              last_o;

  indexed_block_allocator_top i_dut (.*);

  // allocator shadow state
  bit                blk_free [NBLK];
  logic [7:0]        blk_data [NBLK];
  bit                file_used [NFIL];
  logic [ID_W-1:0]   file_ident [NFIL];
  int                file_len [NFIL];
  int                file_map [NFIL][NBLK];
  int                unreserved;
  bit                wr_open;
  int                wr_file;
  int                wr_left;

  result_t           expected_q[$];
  int                errors;
  int                cycles;
  logic [ID_W-1:0]   known_ids[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("indexed_block_allocator_top regression: fail");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void push_result(status_e st, int ch, int blk, bit lst);
    result_t r;
    r.status = st;
    r.ch = ch[7:0];
    r.blk = blk[5:0];
    r.last = lst;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic status_e open_write(int e, int len);
    file_len[e] = 0;
    if (len > unreserved) return ST_NO_SPACE;
    if (len == 0) return ST_OK;
    unreserved -= len;
    wr_open = 1;
    wr_file = e;
    wr_left = len;
    return ST_OK;
  endfunction

  function automatic void predict_allocator(op_e op, logic [ID_W-1:0] id, int len,
                                            logic [7:0] ch);
    int e;
    int b;
    int slot;
    if (op > OP_DELETE) begin
      push_result(ST_DISCARD, 0, 0, 1);
      return;
    end
    if (op == OP_WRITE) begin
      if (!wr_open) begin
        push_result(ST_DISCARD, 0, 0, 1);
        return;
      end
      for (b = 0; b < NBLK && !blk_free[b]; b++) ;
      slot = file_len[wr_file];
      if (b >= NBLK || slot >= NBLK) begin
        wr_open = 0;
        wr_left = 0;
        push_result(ST_NO_SPACE, 0, 0, 1);
        return;
      end
      blk_free[b] = 0;
      blk_data[b] = ch;
      file_map[wr_file][slot] = b;
      file_len[wr_file] = slot + 1;
      if (wr_left > 0) wr_left--;
      if (wr_left == 0) wr_open = 0;
      push_result(ST_OK, 0, b, 1);
      return;
    end
    if (wr_open) begin
      push_result(ST_BUSY, 0, 0, 1);
      return;
    end
    e = -1;
    for (int i = NFIL - 1; i >= 0; i--)
      if (file_used[i] && file_ident[i] == id) e = i;
    if (op == OP_CREATE) begin
      if (e >= 0) begin
        push_result(ST_DUP, 0, 0, 1);
        return;
      end
      for (e = 0; e < NFIL && file_used[e]; e++) ;
      if (e >= NFIL) begin
        push_result(ST_FULL, 0, 0, 1);
        return;
      end
      file_used[e] = 1;
      file_ident[e] = id;
      push_result(open_write(e, len), 0, 0, 1);
      return;
    end
    if (e < 0) begin
      push_result(ST_NOT_FOUND, 0, 0, 1);
      return;
    end
    if (op == OP_READ) begin
      if (file_len[e] == 0) push_result(ST_OK, 0, 0, 1);
      for (int k = 0; k < file_len[e]; k++)
        push_result(ST_OK, blk_data[file_map[e][k]], file_map[e][k],
                    k + 1 == file_len[e]);
      return;
    end
    for (int k = 0; k < file_len[e]; k++) begin
      if (!blk_free[file_map[e][k]]) begin
        blk_free[file_map[e][k]] = 1;
        unreserved++;
      end
    end
    file_len[e] = 0;
    if (op == OP_UPDATE) begin
      push_result(open_write(e, len), 0, 0, 1);
      return;
    end
    file_used[e] = 0;
    push_result(ST_OK, 0, 0, 1);
  endfunction

  // one transaction: random gap, drive, wait for acceptance; valid stays up
  // until the next item or an idle period replaces it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input int len, input logic [7:0] ch, input bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    file_id_i   <= id;
    length_i    <= len[LEN_W-1:0];
    data_char_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_allocator(op_e'(op), id, len, ch);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // begin item followed by its chars
  task automatic send_file(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input int len);
    send_item(op, id, len, 8'h00);
    for (int k = 0; k < len; k++) send_item(OP_WRITE, id, 0, 8'($urandom));
  endtask

  // stall process: out_stall_i is raised before each result, unless the random draw is zero
  initial begin
    int w;
    out_stall_i = 1'b0;
    forever begin
      w = $urandom_range(0, 8);
      @(negedge clk_i);
      if (w != 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status)
          report($sformatf("status %0d exp %0d", status_o, exp_r.status));
        if (out_char_o !== exp_r.ch)
          report($sformatf("out_char %0h exp %0h", out_char_o, exp_r.ch));
        if (block_index_o !== exp_r.blk)
          report($sformatf("block_index %0d exp %0d", block_index_o, exp_r.blk));
        if (last_o !== exp_r.last)
          report($sformatf("last %0b exp %0b", last_o, exp_r.last));
      end
    end
  end

  task automatic test_basic_ops();
    send_file(OP_CREATE, 16'hFFFF, 3);
    send_item(OP_READ, 16'hFFFF, 0, 0);
    send_item(OP_CREATE, 16'hFFFF, 1, 0);         // duplicate
    send_item(OP_READ, 16'h0000, 0, 0);           // missing
    send_item(OP_WRITE, 16'h0, 0, 8'hFF);         // stray char
    send_item(3'd5, 16'h0, 0, 0);
    send_item(3'd7, 16'hFFFF, 127, 8'hFF);
    send_file(OP_CREATE, 16'h0000, 0);            // empty file
    send_item(OP_READ, 16'h0000, 0, 0);
    send_file(OP_UPDATE, 16'hFFFF, 2);
    send_item(OP_READ, 16'hFFFF, 0, 0);
    send_item(OP_DELETE, 16'hFFFF, 0, 0);
    send_item(OP_DELETE, 16'h0000, 0, 0);
    send_item(OP_UPDATE, 16'h1234, 1, 0);         // missing
    wait_drained();
  endtask

  task automatic test_busy_and_space();
    send_item(OP_CREATE, 16'h00A0, 4, 0);
    send_item(OP_READ, 16'h00A0, 0, 0);           // busy
    send_item(OP_CREATE, 16'h00A1, 1, 0);         // busy
    for (int k = 0; k < 4; k++) send_item(OP_WRITE, 0, 0, 8'($urandom));
    send_item(OP_CREATE, 16'h00A2, 64, 0);        // no space, stays empty
    send_item(OP_READ, 16'h00A2, 0, 0);
    send_file(OP_UPDATE, 16'h00A0, 12);
    send_item(OP_UPDATE, 16'h00A0, 17, 0);        // no space, old data freed
    send_item(OP_READ, 16'h00A0, 0, 0);
    send_file(OP_UPDATE, 16'h00A0, 16);           // whole store
    send_item(OP_READ, 16'h00A0, 0, 0);
    send_item(OP_DELETE, 16'h00A0, 0, 0);
    send_item(OP_DELETE, 16'h00A2, 0, 0);
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int f = 0; f <= NFIL; f++) send_file(OP_CREATE, 16'(16'h0100 + f), 1);
    for (int f = 0; f < NFIL; f++) send_item(OP_DELETE, 16'(16'h0100 + f), 0, 0);
    wait_drained();
  endtask

  task automatic test_random(input int items);
    int n;
    int r;
    logic [ID_W-1:0] id;
    n = 0;
    known_ids = {16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0};
    while (n < items) begin
      r = $urandom_range(0, 99);
      id = (r % 10 == 0) ? 16'($urandom) : known_ids[$urandom_range(0, 5)];
      if (r < 40) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
        send_item(($urandom_range(0, 1) != 0) ? OP_CREATE : OP_UPDATE, id, len, 0);
        n++;
        // mostly complete the write, sometimes cut short or overrun
        for (int k = 0; k < len + $urandom_range(0, 1) && k < 18; k++) begin
          if ($urandom_range(0, 15) == 0) break;
          send_item(OP_WRITE, 16'($urandom), 7'($urandom), 8'($urandom));
          n++;
        end
      end else begin
        if (r < 65) send_item(OP_READ, id, 0, 0);
        else if (r < 80) send_item(OP_DELETE, id, 0, 0);
        else if (r < 95) send_item(OP_WRITE, id, 0, 8'($urandom));
        else send_item(3'($urandom_range(5, 7)), 16'($urandom), 7'($urandom), 8'($urandom));
        n++;
      end
      if (n % 70 == 0) wait_drained();
    end
    // back-to-back burst without gaps
    for (int k = 0; k < 10; k++) send_item(OP_READ, known_ids[k % 6], 0, 0, 0);
    // keep open writes from blocking the tail
    for (int k = 0; k < 18; k++) send_item(OP_WRITE, 0, 0, 8'($urandom), 0);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    unreserved = NBLK;
    wr_open = 0;
    wr_file = 0;
    wr_left = 0;
    for (int i = 0; i < NBLK; i++) begin
      blk_free[i] = 1;
      blk_data[i] = '0;
    end
    for (int i = 0; i < NFIL; i++) begin
      file_used[i] = 0;
      file_len[i] = 0;
    end
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    file_id_i = '0;
    length_i = '0;
    data_char_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_basic_ops();
    test_busy_and_space();
    test_full_table();
    test_random(100);
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("indexed_block_allocator_top regression: pass");
    end else begin
      if (expected_q.size() != 0) report("results never arrived");
      $display("indexed_block_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/iba_pkg.sv
sv/iba_dp.sv
sv/iba_ctrl.sv
sv/indexed_block_allocator_top.sv
sim/tb.sv
